### design/rnip_pkg.sv
// Shared types and constants for the ray nearest instance picker.
// Used by rnip_ctrl, rnip_dp and ray_nearest_instance_pick_top; no dependencies.
package rnip_pkg;

    localparam int COORD_W     = 32;
    localparam int SCALE_W     = 16;
    localparam int RADIUS_W    = 24;
    localparam int INDEX_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int MUL_W       = 38;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 72;
    localparam int LEN_W       = 36;
    localparam int DIR_SHIFT   = 30;
    localparam int QUOT_W      = 31;
    localparam int DREM_W      = 34;
    localparam int SQRT_STEPS  = 36;
    localparam int DIV_STEPS   = 31;
    localparam int CNT_W       = 6;
    localparam int IN_DATA_W   = 144;
    localparam int OUT_DATA_W  = 112;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd12800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X,
        CFG_START_Y,
        CFG_START_Z,
        CFG_END_X,
        CFG_END_Y,
        CFG_END_Z,
        CFG_RADIUS
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_D,
        MUL_DOT,
        MUL_PT,
        MUL_E
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_CLR,
        ACC_ADD,
        ACC_PT
    } acc_op_t;

    typedef struct packed {
        logic       cfg_wr;
        logic       load_item;
        mul_op_t    mul_op;
        logic [1:0] mul_axis;
        acc_op_t    acc_op;
        logic [1:0] acc_axis;
        logic       sq_init;
        logic       sq_step;
        logic       len_load;
        logic       div_init;
        logic       div_step;
        logic       dir_load;
        logic [1:0] div_axis;
        logic       proj_load;
        logic       best_update;
        logic       count_inc;
        logic       out_load;
        logic       query_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic ray_cfg;
        logic proj_ok;
        logic hit_ok;
        logic is_last;
        logic out_busy;
    } dp_sts_t;

endpackage

### design/rnip_ctrl.sv
// Sequencer for the ray nearest instance picker: steps the datapath through
// ray setup and per-instance scoring. Depends on rnip_pkg.
module rnip_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              s_tvalid,
    output logic              s_tready,
    output rnip_pkg::dp_cmd_t cmd,
    input  rnip_pkg::dp_sts_t sts
);
    import rnip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSQ,
        S_RSQRT,
        S_RLEN,
        S_DIV,
        S_DIR,
        S_DOT,
        S_PROJ,
        S_PT,
        S_ESQ,
        S_DSQRT,
        S_CMP,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       axis_reg, axis_next;
    logic [1:0]       cnt_axis;
    logic [1:0]       prev_axis;

    assign cnt_axis  = cnt_reg[1:0];
    assign prev_axis = cnt_reg[1:0] - 2'd1;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (cfg_valid)
                begin
                    cmd.cfg_wr = 1'b1;
                    if (sts.ray_cfg)
                    begin
                        state_next = S_RSQ;
                    end
                end
                else if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DOT;
                end
            end
            S_RSQ, S_DOT, S_PT, S_ESQ:
            begin
                if (cnt_reg < CNT_W'(3))
                begin
                    cmd.mul_axis = cnt_axis;
                    case (state_reg)
                        S_RSQ:   cmd.mul_op = MUL_D;
                        S_DOT:   cmd.mul_op = MUL_DOT;
                        S_PT:    cmd.mul_op = MUL_PT;
                        default: cmd.mul_op = MUL_E;
                    endcase
                end
                cmd.acc_axis = prev_axis;
                if (cnt_reg == '0)
                begin
                    cmd.acc_op = (state_reg == S_PT) ? ACC_NONE : ACC_CLR;
                end
                else
                begin
                    cmd.acc_op = (state_reg == S_PT) ? ACC_PT : ACC_ADD;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next = '0;
                    case (state_reg)
                        S_RSQ:   state_next = S_RSQRT;
                        S_DOT:   state_next = S_PROJ;
                        S_PT:    state_next = S_ESQ;
                        default: state_next = S_DSQRT;
                    endcase
                end
            end
            S_RSQRT, S_DSQRT:
            begin
                cmd.sq_init = (cnt_reg == '0);
                cmd.sq_step = (cnt_reg != '0);
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_RSQRT) ? S_RLEN : S_CMP;
                end
            end
            S_RLEN:
            begin
                cmd.len_load = 1'b1;
                axis_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_axis = axis_reg;
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                cmd.dir_load = 1'b1;
                cmd.div_axis = axis_reg;
                if (axis_reg == 2'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIV;
                end
            end
            S_PROJ:
            begin
                cmd.proj_load = 1'b1;
                state_next    = sts.proj_ok ? S_PT : S_DONE;
            end
            S_CMP:
            begin
                cmd.best_update = sts.hit_ok;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.is_last)
                begin
                    cmd.count_inc = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.query_clr = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

`ifndef SYNTHESIS
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over an untaken result");
    a_item_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DOT))
        else $error("accepted item did not start scoring");
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !sts.is_last) |=> (state_reg == S_IDLE))
        else $error("non-final item did not retire");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (!cmd.cfg_wr && !cmd.load_item))
        else $error("transfer taken while busy");
`endif

endmodule

### design/rnip_dp.sv
// Datapath of the ray nearest instance picker: configuration registers, shared
// multiplier, accumulator, square root and divider units, best hit and result.
// Depends on rnip_pkg.
module rnip_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rnip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rnip_pkg::COORD_W-1:0]   cfg_data,
    input  logic [rnip_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rnip_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    input  rnip_pkg::dp_cmd_t              cmd,
    output rnip_pkg::dp_sts_t              sts
);
    import rnip_pkg::*;

    logic signed [COORD_W-1:0]  start_reg [3];
    logic signed [COORD_W-1:0]  end_reg [3];
    logic [RADIUS_W-1:0]        base_radius_reg;
    logic signed [COORD_W-1:0]  dir_reg [3];
    logic [LEN_W-1:0]           len_reg;

    logic signed [COORD_W-1:0]  pos_reg [3];
    logic [SCALE_W-1:0]         smax_reg;
    logic                       last_reg;

    logic signed [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic signed [MUL_W-1:0]    e_reg [3];
    logic signed [36:0]         pt_reg [3];
    logic signed [34:0]         proj_reg;
    logic [COORD_W-1:0]         radius_reg;

    logic [ACC_W-1:0]           rad_reg;
    logic [MUL_W-1:0]           rem_reg;
    logic [LEN_W-1:0]           root_reg;

    logic [DREM_W-1:0]          drem_reg;
    logic [QUOT_W-1:0]          quot_reg;
    logic                       dbit_reg;
    logic                       dneg_reg;

    logic [COORD_W-1:0]         best_dist_reg;
    logic [INDEX_W-1:0]         best_index_reg;
    logic signed [COORD_W-1:0]  best_pt_reg [3];
    logic                       found_reg;
    logic [INDEX_W-1:0]         count_reg;

    logic                       m_tvalid_reg;
    logic [OUT_DATA_W-1:0]      m_tdata_reg;
    logic                       m_tuser_reg;

    cfg_idx_t                   idx;
    logic signed [32:0]         d_vec [3];
    logic signed [32:0]         to_vec [3];
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic [SCALE_W-1:0]         in_scale [3];
    logic [SCALE_W-1:0]         in_smax;
    logic [39:0]                radius_prod;
    logic signed [PROD_W-1:0]   pt_term;
    logic signed [36:0]         pt_val;
    logic [MUL_W+1:0]           rem2;
    logic [MUL_W+1:0]           trial;
    logic [32:0]                d_mag;
    logic [DREM_W:0]            dr2;
    logic [LEN_W-1:0]           dr2_ext;
    logic [COORD_W-1:0]         dist_sat;
    logic signed [COORD_W-1:0]  pt_sat [3];

    assign idx = cfg_idx_t'(cfg_index);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_vec[i]  = 33'(end_reg[i]) - 33'(start_reg[i]);
            to_vec[i] = 33'(pos_reg[i]) - 33'(start_reg[i]);
            if (pt_reg[i] > 37'sd2147483647)
            begin
                pt_sat[i] = 32'sh7FFFFFFF;
            end
            else if (pt_reg[i] < -37'sd2147483648)
            begin
                pt_sat[i] = 32'sh80000000;
            end
            else
            begin
                pt_sat[i] = pt_reg[i][COORD_W-1:0];
            end
        end
        in_scale[0] = s_tdata[111:96];
        in_scale[1] = s_tdata[127:112];
        in_scale[2] = s_tdata[143:128];
        in_smax = in_scale[0];
        if (in_scale[1] > in_smax)
        begin
            in_smax = in_scale[1];
        end
        if (in_scale[2] > in_smax)
        begin
            in_smax = in_scale[2];
        end
    end

    always_comb
    begin
        case (cmd.mul_op)
            MUL_D:
            begin
                mul_a = MUL_W'(d_vec[cmd.mul_axis]);
                mul_b = MUL_W'(d_vec[cmd.mul_axis]);
            end
            MUL_DOT:
            begin
                mul_a = MUL_W'(to_vec[cmd.mul_axis]);
                mul_b = MUL_W'(dir_reg[cmd.mul_axis]);
            end
            MUL_PT:
            begin
                mul_a = MUL_W'(dir_reg[cmd.mul_axis]);
                mul_b = MUL_W'(proj_reg);
            end
            MUL_E:
            begin
                mul_a = e_reg[cmd.mul_axis];
                mul_b = e_reg[cmd.mul_axis];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign radius_prod = 40'(base_radius_reg) * 40'(smax_reg);
    assign pt_term     = prod_reg >>> DIR_SHIFT;
    assign pt_val      = 37'(start_reg[cmd.acc_axis]) + pt_term[36:0];
    assign rem2        = {rem_reg, rad_reg[ACC_W-1 -: 2]};
    assign trial       = {2'b00, root_reg, 2'b01};
    assign d_mag       = d_vec[cmd.div_axis][32] ? (33'd0 - d_vec[cmd.div_axis])
                                                 : d_vec[cmd.div_axis];
    assign dr2         = {drem_reg, dbit_reg};
    assign dr2_ext     = LEN_W'(dr2);
    assign dist_sat    = (root_reg[LEN_W-1:COORD_W] != '0) ? '1 : root_reg[COORD_W-1:0];

    assign sts.ray_cfg  = (idx == CFG_START_X) || (idx == CFG_START_Y) ||
                          (idx == CFG_START_Z) || (idx == CFG_END_X) ||
                          (idx == CFG_END_Y) || (idx == CFG_END_Z);
    assign sts.proj_ok  = !acc_reg[63] && (LEN_W'(acc_reg[62:DIR_SHIFT]) <= len_reg);
    assign sts.hit_ok   = (dist_sat < radius_reg) && (dist_sat < best_dist_reg);
    assign sts.is_last  = last_reg;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Unreset working registers: item fields, products, unit state and output data.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pos_reg[0] <= s_tdata[31:0];
            pos_reg[1] <= s_tdata[63:32];
            pos_reg[2] <= s_tdata[95:64];
            smax_reg   <= in_smax;
            last_reg   <= s_tlast;
        end
        prod_reg <= mul_a * mul_b;
        case (cmd.acc_op)
            ACC_CLR: acc_reg <= '0;
            ACC_ADD: acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            ACC_PT:
            begin
                pt_reg[cmd.acc_axis] <= pt_val;
                e_reg[cmd.acc_axis]  <= MUL_W'(pos_reg[cmd.acc_axis]) - MUL_W'(pt_val);
            end
            default: acc_reg <= acc_reg;
        endcase
        if (cmd.proj_load)
        begin
            proj_reg   <= 35'(signed'(acc_reg[63:DIR_SHIFT]));
            radius_reg <= radius_prod[39:8];
        end
        if (cmd.sq_init)
        begin
            rad_reg  <= acc_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            rad_reg <= rad_reg << 2;
            if (rem2 >= trial)
            begin
                rem_reg  <= MUL_W'(rem2 - trial);
                root_reg <= {root_reg[LEN_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= MUL_W'(rem2);
                root_reg <= {root_reg[LEN_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            drem_reg <= DREM_W'(d_mag[32:1]);
            dbit_reg <= d_mag[0];
            dneg_reg <= d_vec[cmd.div_axis][32];
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dbit_reg <= 1'b0;
            if (dr2_ext >= len_reg)
            begin
                drem_reg <= DREM_W'(dr2_ext - len_reg);
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= DREM_W'(dr2);
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {best_pt_reg[2], best_pt_reg[1], best_pt_reg[0], best_index_reg};
            m_tuser_reg <= found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                start_reg[i]   <= '0;
                end_reg[i]     <= '0;
                dir_reg[i]     <= '0;
                best_pt_reg[i] <= '0;
            end
            base_radius_reg <= RADIUS_RESET;
            len_reg         <= '0;
            best_dist_reg   <= '1;
            best_index_reg  <= '0;
            found_reg       <= 1'b0;
            count_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                case (idx)
                    CFG_START_X: start_reg[0]    <= cfg_data;
                    CFG_START_Y: start_reg[1]    <= cfg_data;
                    CFG_START_Z: start_reg[2]    <= cfg_data;
                    CFG_END_X:   end_reg[0]      <= cfg_data;
                    CFG_END_Y:   end_reg[1]      <= cfg_data;
                    CFG_END_Z:   end_reg[2]      <= cfg_data;
                    CFG_RADIUS:  base_radius_reg <= cfg_data[RADIUS_W-1:0];
                    default:     base_radius_reg <= base_radius_reg;
                endcase
            end
            if (cmd.len_load)
            begin
                len_reg <= root_reg;
            end
            if (cmd.dir_load)
            begin
                if (len_reg == '0)
                begin
                    dir_reg[cmd.div_axis] <= '0;
                end
                else if (dneg_reg)
                begin
                    dir_reg[cmd.div_axis] <= COORD_W'(0) - COORD_W'(quot_reg);
                end
                else
                begin
                    dir_reg[cmd.div_axis] <= COORD_W'(quot_reg);
                end
            end
            if (cmd.best_update)
            begin
                best_dist_reg  <= dist_sat;
                best_index_reg <= count_reg;
                found_reg      <= 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    best_pt_reg[i] <= pt_sat[i];
                end
            end
            if (cmd.query_clr)
            begin
                count_reg      <= '0;
                best_dist_reg  <= '1;
                best_index_reg <= '0;
                found_reg      <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    best_pt_reg[i] <= '0;
                end
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + INDEX_W'(1);
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

### design/ray_nearest_instance_pick_top.sv
// Top level of the ray nearest instance picker: joins the sequencer and datapath.
// Depends on rnip_pkg, rnip_ctrl and rnip_dp.
//
// Streams instance centres and scales against a ray segment held in registers and
// returns, on the item marked tlast, the index of the closest instance hit and the
// nearest ray point. One item at a time is scored, and the next is not taken until
// the last is done. An item whose projection falls outside the segment skips the
// distance steps; a scored item's time is set mostly by the 36-step square root
// behind a shared 38 by 38 bit multiplier. A write to a ray register recomputes
// length and direction, during which no transfer is taken; a radius write does not
// recompute. A result waits in an output register, and non-final items keep flowing
// while it is not taken; a final item waits until it is.
module ray_nearest_instance_pick_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rnip_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rnip_pkg::COORD_W-1:0]     cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z
    input  logic [rnip_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit_index, hit_x, hit_y, hit_z
    output logic [rnip_pkg::OUT_DATA_W-1:0]  m_tdata,
    // hit
    output logic                             m_tuser
);
    import rnip_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rnip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rnip_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### verif/tb_ray_nearest_instance_pick_top.sv
// Self-checking testbench for ray_nearest_instance_pick_top: streams instances against
// several ray settings and compares each result with a built-in fixed-point predictor.
// Depends on rnip_pkg and the design files only.
module tb_ray_nearest_instance_pick_top;
    import rnip_pkg::*;

    typedef struct {
        logic [IN_DATA_W-1:0] data;
        logic                 last;
    } instance_t;

    typedef struct {
        logic              hit;
        logic [15:0]       index;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
    } pick_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_W-1:0]    cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    instance_t pending_q[$];
    pick_t     pick_q[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        cycle = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    bit        s_took = 1'b0;

    // Predictor state.
    logic [31:0]    ray_reg [7];
    logic [15:0]    inst_count;
    logic [31:0]    near_dist;
    logic [15:0]    near_index;
    longint         near_point [3];
    bit             near_found;
    longint         ray_dir [3];
    longint         ray_len;

    ray_nearest_instance_pick_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic longint root3(longint a, longint b, longint c);
        logic [127:0] ma, mb, mc, sum, cand;
        longint r;
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        mc = 128'(c < 0 ? -c : c);
        sum = ma * ma + mb * mb + mc * mc;
        r = 0;
        for (int bit_i = 35; bit_i >= 0; bit_i--) begin
            cand = 128'(r | (64'd1 << bit_i));
            if (cand * cand <= sum)
                r = r | (64'd1 << bit_i);
        end
        return r;
    endfunction

    function automatic void refresh_ray();
        longint d [3];
        logic [127:0] q;
        for (int i = 0; i < 3; i++)
            d[i] = longint'($signed(ray_reg[3+i])) - longint'($signed(ray_reg[i]));
        ray_len = root3(d[0], d[1], d[2]);
        for (int i = 0; i < 3; i++) begin
            if (ray_len == 0) begin
                ray_dir[i] = 0;
            end else begin
                q = (128'(d[i] < 0 ? -d[i] : d[i]) << DIR_SHIFT) / 128'(ray_len);
                ray_dir[i] = d[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
            end
        end
    endfunction

    function automatic void clear_pick();
        inst_count = '0;
        near_dist = '1;
        near_index = '0;
        near_found = 1'b0;
        for (int i = 0; i < 3; i++)
            near_point[i] = 0;
    endfunction

    function automatic void score_instance(instance_t it);
        longint pos [3], st [3], pt [3], e [3];
        logic signed [127:0] acc, wa, wb;
        longint proj, pt_dist, smax, radius, sh;
        pick_t res;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(it.data[32*i +: 32]));
            st[i] = longint'($signed(ray_reg[i]));
            wa = pos[i] - st[i];
            wb = ray_dir[i];
            acc = acc + wa * wb;
        end
        proj = $signed(acc[63:0]) >>> DIR_SHIFT;
        if (proj >= 0 && proj <= ray_len) begin
            for (int i = 0; i < 3; i++) begin
                wa = ray_dir[i];
                wb = proj;
                wa = wa * wb;
                sh = $signed(wa[63:0]) >>> DIR_SHIFT;
                pt[i] = st[i] + sh;
                e[i] = pos[i] - pt[i];
            end
            pt_dist = root3(e[0], e[1], e[2]);
            if (pt_dist > 64'hFFFF_FFFF)
                pt_dist = 64'hFFFF_FFFF;
            smax = it.data[96 +: 16];
            if (it.data[112 +: 16] > smax) smax = it.data[112 +: 16];
            if (it.data[128 +: 16] > smax) smax = it.data[128 +: 16];
            radius = (longint'(ray_reg[CFG_RADIUS][23:0]) * smax) >>> 8;
            if (pt_dist < radius && pt_dist < longint'(near_dist)) begin
                near_dist = pt_dist[31:0];
                near_index = inst_count;
                near_found = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    near_point[i] = pt[i];
                    if (near_point[i] > 64'sd2147483647) near_point[i] = 64'sd2147483647;
                    if (near_point[i] < -64'sd2147483648) near_point[i] = -64'sd2147483648;
                end
            end
        end
        inst_count = inst_count + 16'd1;
        if (it.last) begin
            res.hit = near_found;
            res.index = near_found ? near_index : 16'd0;
            res.px = near_found ? near_point[0][31:0] : 32'd0;
            res.py = near_found ? near_point[1][31:0] : 32'd0;
            res.pz = near_found ? near_point[2][31:0] : 32'd0;
            pick_q.push_back(res);
            clear_pick();
        end
    endfunction

    // Input side: sample transfers at the rising edge, drive at the falling edge.
    always @(posedge clk) begin
        s_took = s_tvalid && s_tready;
        if (s_took) begin
            score_instance(pending_q[0]);
            void'(pending_q.pop_front());
        end
    end

    always @(negedge clk) begin
        if (!(s_tvalid && !s_took)) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_q[0].data;
                s_tlast <= pending_q[0].last;
                if (burst_left > 0)
                    burst_left--;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: the receiver stalls on one of four patterns in turn.
    always @(negedge clk) begin
        case ((cycle / 400) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle % 16) < 5;
            default: m_tready <= (cycle % 7) != 0;
        endcase
    end

    always @(posedge clk) begin
        pick_t want;
        cycle++;
        if (m_tvalid && m_tready) begin
            if (pick_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: hit=%0d data=%h", m_tuser, m_tdata);
            end else begin
                want = pick_q.pop_front();
                if (m_tuser !== want.hit || m_tdata[15:0] !== want.index
                        || m_tdata[47:16] !== want.px || m_tdata[79:48] !== want.py
                        || m_tdata[111:80] !== want.pz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected hit=%0d idx=%0d pt=%h,%h,%h",
                                  " got hit=%0d idx=%0d pt=%h,%h,%h"},
                            want.hit, want.index, want.px, want.py, want.pz, m_tuser,
                            m_tdata[15:0], m_tdata[47:16], m_tdata[79:48], m_tdata[111:80]);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 6000) begin
            $display("tb_ray_nearest_instance_pick_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= CFG_RADIUS) begin
            ray_reg[idx] = (idx == CFG_RADIUS) ? {8'd0, value[23:0]} : value;
            if (idx != CFG_RADIUS)
                refresh_ray();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ray(logic [31:0] sx, sy, sz, ex, ey, ez, logic [23:0] radius);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
        write_reg(CFG_START_Z, sz);
        write_reg(CFG_END_X, ex);
        write_reg(CFG_END_Y, ey);
        write_reg(CFG_END_Z, ez);
        write_reg(CFG_RADIUS, {8'd0, radius});
    endtask

    task automatic add_instance(logic [31:0] px, py, pz, logic [15:0] sx, sy, sz, logic last);
        instance_t it;
        it.data = {sz, sy, sx, pz, py, px};
        it.last = last;
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] along_ray(int axis, int k, longint noise);
        longint s, e, v;
        s = longint'($signed(ray_reg[axis]));
        e = longint'($signed(ray_reg[3+axis]));
        v = s + ((e - s) * k) / 256 + noise;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(64, 600));
        endcase
    endfunction

    task automatic random_instances(int count);
        int k;
        longint spread;
        logic [31:0] p [3];
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 300) - 20
                                              : $urandom_range(0, 256);
                spread = longint'(ray_reg[CFG_RADIUS][23:0]) * $urandom_range(0, 6);
                for (int i = 0; i < 3; i++)
                    p[i] = along_ray(i, k, longint'($urandom_range(0, 2000)) * spread / 1000
                                           - spread);
            end else begin
                for (int i = 0; i < 3; i++)
                    p[i] = $urandom;
            end
            add_instance(p[0], p[1], p[2], rand_scale(), rand_scale(), rand_scale(),
                         $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || pick_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial begin
        for (int i = 0; i < 7; i++)
            ray_reg[i] = '0;
        ray_reg[CFG_RADIUS] = {8'd0, RADIUS_RESET};
        refresh_ray();
        clear_pick();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero-length ray after reset: everything is tested against the start point.
        add_instance(32'd0, 32'd0, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_instance(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        add_instance(32'd1000, 32'd0, 32'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        add_instance(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 1'b1);
        drain();

        // Axis ray: before start, past end, ties, and a query with no hit.
        set_ray(32'd0, 32'd0, 32'd0, 32'd256000, 32'd0, 32'd0, 24'd12800);
        add_instance(-32'sd25600, 32'd0, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_instance(32'd300000, 32'd0, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_instance(32'd1000, 32'd2560, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_instance(32'd5000, 32'd2560, 32'd0, 16'h0100, 16'h0200, 16'h0080, 1'b0);
        add_instance(32'd9000, 32'd256, 32'd0, 16'h0010, 16'h0100, 16'h0100, 1'b1);
        add_instance(32'd9000, 32'd999999, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b1);
        add_instance(32'd0, 32'd0, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_instance(32'd256000, 32'd0, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b1);
        drain();

        // Extreme segment so that hit points saturate; an ignored register index too.
        set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        add_instance(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 1'b0);
        add_instance(32'h7FFF_FF00, 32'h7FFF_FF00, 32'h7FFF_FF00, 16'hFFFF, 16'h0001,
                     16'h0001, 1'b1);
        random_instances(300);
        drain();

        // Query left open across a ray change, then random rays and radii.
        add_instance(32'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        drain();
        set_ray(32'd512, 32'd0, 32'd0, 32'd512, 32'd0, 32'd0, 24'd0);
        random_instances(100);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            set_ray($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000) - 100000,
                    $urandom_range(0, 200000) - 100000, $urandom_range(0, 200000) - 100000,
                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400000) - 200000,
                    $urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
                    24'($urandom_range(0, 3) == 0 ? $urandom
                                                  : $urandom_range(256, 40000)));
            random_instances(260);
            drain();
        end

        set_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 24'd12800);
        random_instances(20);
        add_instance(32'd0, 32'd0, 32'd0, 16'h0100, 16'h0100, 16'h0100, 1'b1);
        drain();

        if (mismatches == 0)
            $display("tb_ray_nearest_instance_pick_top: done, clean");
        else
            $display("tb_ray_nearest_instance_pick_top: done, errors");
        $finish;
    end
endmodule
